[rtl/wosn_pkg.sv]
`timescale 1ns / 1ps

package wosn_pkg;

  // Payload and register widths
  localparam int FIELD_W            = 16;
  localparam int LEN_W              = 5;
  localparam int MAX_LENGTH_DEFAULT = 16;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register index, taken from the word address bit paddr[2]
  localparam logic REG_ACTIVE_LENGTH = 1'b0;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

  // Bus signals of one configuration transfer
  typedef struct packed {
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
  } wosn_apb_t;

  // One result item
  typedef struct packed {
    logic [FIELD_W-1:0] next_pattern;
    logic               more;
  } wosn_result_t;

endpackage

[rtl/weight_ordered_subset_next.sv]
`timescale 1ns / 1ps

// Weight-ordered subset successor. Each start transfer hands in one pattern
// and the successor appears on next_pattern/more with done high for one
// cycle: the accepting edge loads the input register, and the result register
// then captures the output of one pass of successor logic. busy never rises,
// so a new pattern can be started in every cycle and results come out at the
// same rate, in order; the receiver must take each result in its done cycle.
// active_length is set over the APB port at address 0 and must only change
// while no pattern is in flight.

module weight_ordered_subset_next #(
  parameter int MAX_LENGTH = wosn_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wosn_pkg::ADDR_W-1:0]   paddr,
  input  logic [wosn_pkg::DATA_W-1:0]   pwdata,
  output logic [wosn_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  logic [wosn_pkg::FIELD_W-1:0]  current_pattern,
  // result side
  output logic                          done,
  output logic [wosn_pkg::FIELD_W-1:0]  next_pattern,
  output logic                          more
);

  wosn_pkg::wosn_apb_t            apb;
  wosn_pkg::wosn_result_t         step_result;
  logic [wosn_pkg::LEN_W-1:0]     active_length;
  logic                           in_valid;
  logic [wosn_pkg::FIELD_W-1:0]   in_pattern;
  logic                           accept;

  assign apb.psel    = psel;
  assign apb.penable = penable;
  assign apb.pwrite  = pwrite;
  assign apb.paddr   = paddr;
  assign apb.pwdata  = pwdata;
  assign pready      = 1'b1;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  wosn_cfg_regs u_cfg (
    .clk           (clk),
    .rst           (rst),
    .apb           (apb),
    .prdata        (prdata),
    .active_length (active_length)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_pattern <= current_pattern;
    end
  end

  wosn_step #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_step (
    .active_length (active_length),
    .pattern       (in_pattern),
    .result        (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      next_pattern <= step_result.next_pattern;
      more         <= step_result.more;
    end
  end

  // Every accepted transfer yields one result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("accepted pattern produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_valid))
    else $error("result without a pattern in the input register");

  // A fresh combination is never empty
  a_more_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && more) |-> (next_pattern != '0))
    else $error("new combination is empty");

  // Exhausted means every active position is set
  a_exhausted_full: assert property (@(posedge clk) disable iff (rst)
    (done && !more) |->
      ($countones(next_pattern) ==
       ((int'(active_length) > MAX_LENGTH) ? MAX_LENGTH : int'(active_length))))
    else $error("exhausted result is not the full pattern");

endmodule

[rtl/wosn_cfg_regs.sv]
`timescale 1ns / 1ps

module wosn_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  wosn_pkg::wosn_apb_t                 apb,
  output logic [wosn_pkg::DATA_W-1:0]         prdata,
  output logic [wosn_pkg::LEN_W-1:0]          active_length
);

  logic wr_en;
  logic sel_len;

  // Register decode on the word address
  assign sel_len = (apb.paddr[2] == wosn_pkg::REG_ACTIVE_LENGTH);
  assign wr_en   = apb.psel && apb.penable && apb.pwrite;

  // active_length register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_length <= wosn_pkg::LEN_RESET;
    end else if (wr_en && sel_len) begin
      active_length <= apb.pwdata[wosn_pkg::LEN_W-1:0];
    end
  end

  // Read data
  always_comb begin
    prdata = '0;
    if (sel_len) begin
      prdata = wosn_pkg::DATA_W'(active_length);
    end
  end

endmodule

[rtl/wosn_step.sv]
`timescale 1ns / 1ps

module wosn_step #(
  parameter int MAX_LENGTH = wosn_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic [wosn_pkg::LEN_W-1:0]   active_length,
  input  logic [wosn_pkg::FIELD_W-1:0] pattern,
  output wosn_pkg::wosn_result_t       result
);

  // Working width: the 5-bit length register cannot ask for more than 31
  localparam int PW = (MAX_LENGTH < 31) ? MAX_LENGTH : 31;
  localparam int CW = $clog2(PW + 1);

  logic [CW-1:0] n;
  logic [PW-1:0] m;
  logic [PW-1:0] p;
  logic [CW-1:0] ones;
  logic [PW-1:0] h;
  logic          last_set;
  logic [PW-1:0] b;
  logic [PW-1:0] g;
  logic [CW-1:0] ip;
  logic [PW-1:0] keep;
  logic [CW-1:0] run;
  logic [PW-1:0] run_mask;
  logic [PW-1:0] first_mask;
  logic [PW-1:0] r;
  logic          more;

  // Saturated length and mask of the active positions
  always_comb begin
    if (active_length > wosn_pkg::LEN_W'(PW)) begin
      n = CW'(PW);
    end else begin
      n = CW'(active_length);
    end
    for (int i = 0; i < PW; i++) begin
      m[i] = (CW'(i) < n);
    end
  end

  assign p        = PW'(pattern) & m;
  assign ones     = CW'($countones(p));
  // one-hot of position n-1; set bit there means the top is occupied
  assign last_set = |(p & (m ^ (m >> 1)));

  // Highest one, and highest one with a zero just above it
  always_comb begin
    b = '0;
    for (int i = 0; i < PW - 1; i++) begin
      b[i] = p[i] && !p[i+1] && m[i+1];
    end
    for (int i = 0; i < PW; i++) begin
      h[i] = p[i] && ((p >> (i + 1)) == '0);
      g[i] = b[i] && ((b >> (i + 1)) == '0);
    end
  end

  // Position of the pivot, ones kept below it and ones moved above it
  always_comb begin
    ip = '0;
    for (int i = 0; i < PW; i++) begin
      if (g[i]) begin
        ip = ip | CW'(i);
      end
    end
  end

  assign keep = p & (g - PW'(1));
  assign run  = CW'($countones(p & ~(g - PW'(1))));

  // Thermometer masks: run ones, and ones + 1 ones from bit zero
  always_comb begin
    for (int i = 0; i < PW; i++) begin
      run_mask[i]   = (CW'(i) < run);
      first_mask[i] = (CW'(i) <= ones);
    end
  end

  // Successor selection
  always_comb begin
    r    = p;
    more = 1'b1;
    priority if (n == '0 || p == m) begin
      r    = p;
      more = 1'b0;
    end else if (p == '0) begin
      r = PW'(1);
    end else if (!last_set) begin
      r = (p & ~h) | (h << 1);
    end else if (g != '0) begin
      r = (keep | ((run_mask << ip) << 1)) & m;
    end else begin
      r = first_mask;
    end
  end

  assign result.next_pattern = wosn_pkg::FIELD_W'(r);
  assign result.more         = more;

endmodule
